FILE: rtl/core/execute_stage_alu_with_flags_core_macros.svh
// Assertion helpers for the execute stage RTL in this folder.
// Each macro checks one implication on the rising clock edge and is
// switched off while the active-low reset is asserted.
`ifndef EXECUTE_STAGE_ALU_WITH_FLAGS_CORE_MACROS_SVH
`define EXECUTE_STAGE_ALU_WITH_FLAGS_CORE_MACROS_SVH

// Same-cycle implication.
`define ESALU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ESALU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/esalu_pkg.sv
package esalu_pkg;

    // Opcodes that need their own handling. All other codes pass the first operand.
    localparam logic [5:0] OP_ADD    = 6'd0;
    localparam logic [5:0] OP_SUB    = 6'd1;
    localparam logic [5:0] OP_MUL    = 6'd2;
    localparam logic [5:0] OP_QUOT   = 6'd3;
    localparam logic [5:0] OP_REM    = 6'd4;
    localparam logic [5:0] OP_SFTR   = 6'd5;
    localparam logic [5:0] OP_SFTL   = 6'd6;
    localparam logic [5:0] OP_AND    = 6'd7;
    localparam logic [5:0] OP_OR     = 6'd8;
    localparam logic [5:0] OP_NOT    = 6'd9;
    localparam logic [5:0] OP_XOR    = 6'd10;
    localparam logic [5:0] OP_CMP    = 6'd15;
    localparam logic [5:0] OP_LOAD   = 6'd17;
    localparam logic [5:0] OP_ADDI   = 6'd19;
    localparam logic [5:0] OP_SUBI   = 6'd20;
    localparam logic [5:0] OP_SFTRI  = 6'd21;
    localparam logic [5:0] OP_SFTLI  = 6'd22;
    localparam logic [5:0] OP_ANDI   = 6'd23;
    localparam logic [5:0] OP_ORI    = 6'd24;
    localparam logic [5:0] OP_XORI   = 6'd25;
    localparam logic [5:0] OP_STORE  = 6'd26;
    localparam logic [5:0] OP_JMP    = 6'd28;
    localparam logic [5:0] OP_JRL    = 6'd29;
    localparam logic [5:0] OP_JAL    = 6'd30;
    localparam logic [5:0] OP_BEQ    = 6'd31;
    localparam logic [5:0] OP_BGT    = 6'd32;
    localparam logic [5:0] OP_BUF    = 6'd33;
    localparam logic [5:0] OP_BOF    = 6'd34;
    localparam logic [5:0] OP_PUSH   = 6'd35;
    localparam logic [5:0] OP_POP    = 6'd36;

    localparam logic [31:0] DIV_ZERO_VALUE = 32'h7FFF_FFFF;
    localparam logic [31:0] NOT_TAKEN      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [5:0]  mode;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [31:0] immediate_operand;
        logic [31:0] program_counter;
        logic        ext_underflow;
        logic        ext_overflow;
    } item_t;

    // Two's complement magnitude; the most negative value maps to 2^31.
    function automatic logic [31:0] magnitude(input logic [31:0] value);
        magnitude = value[31] ? (32'd0 - value) : value;
    endfunction

endpackage

FILE: rtl/core/execute_stage_alu_with_flags_core.sv
// Execute stage with stored compare flags.
// Input channel (s_*): one instruction per transfer. s_tuser carries the opcode,
// s_tdata carries the operands, the program counter and the two external flags.
// Output channel (m_*): exactly one result per instruction, in order, with the
// halt flag beside the 32-bit result.
// An accepted instruction is held in an operand register. Operations other
// than a nonzero-divisor division are computed in the following cycle and
// written to the output register once it is free; no new instruction is taken
// until that result is written. QUOT and REM with a nonzero divisor run
// through a radix-2 restoring divider that makes one quotient bit per cycle,
// then the execute state applies the sign fix-up and writes the result.
// s_tready is high only while the sequencer is idle. When the receiver stalls,
// the finished result waits in the output register; the next instruction is
// still accepted, and its own result waits in the sequencer until the output
// register is free.
// Reset clears the sequencer, the output valid bit and both compare flags.
`include "execute_stage_alu_with_flags_core_macros.svh"

module execute_stage_alu_with_flags_core
    import esalu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, from bit 0: first_operand[31:0], second_operand[31:0],
    // immediate_operand[31:0], program_counter[31:0], ext_underflow,
    // ext_overflow, six zero bits.
    input  logic [135:0] s_tdata,
    // s_tuser, from bit 0: mode[5:0].
    input  logic [5:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, from bit 0: result[31:0], halt, seven zero bits.
    output logic [39:0]  m_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0]  state_reg, state_next;
    item_t       in_item;
    item_t       op_reg, op_next;

    // Divider working registers.
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        greater_reg, greater_next;
    logic        equal_reg, equal_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_result_reg, out_result_next;
    logic        out_halt_reg, out_halt_next;

    logic        in_accept;
    logic        out_free;
    logic        in_div;

    logic [32:0] div_shifted;
    logic [32:0] div_diff;
    logic        div_borrow;

    logic [31:0] alu_result;
    logic        alu_halt;
    logic [31:0] mul_product;
    logic [31:0] quot_final;
    logic [31:0] rem_final;

    assign in_item.mode              = s_tuser;
    assign in_item.first_operand     = s_tdata[31:0];
    assign in_item.second_operand    = s_tdata[63:32];
    assign in_item.immediate_operand = s_tdata[95:64];
    assign in_item.program_counter   = s_tdata[127:96];
    assign in_item.ext_underflow     = s_tdata[128];
    assign in_item.ext_overflow      = s_tdata[129];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_div    = ((in_item.mode == OP_QUOT) || (in_item.mode == OP_REM))
                       && (in_item.second_operand != 32'd0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_halt_reg, out_result_reg};

    // One restoring step: bring in the next dividend bit and try to subtract.
    // The partial remainder stays below the divisor, which is at most 2^31,
    // so the shifted value fits 32 bits and bit 32 of the difference is the borrow.
    assign div_shifted = {rem_reg, quo_reg[31]};
    assign div_diff    = div_shifted - {1'b0, dvs_reg};
    assign div_borrow  = div_diff[32];

    assign mul_product = op_reg.first_operand * op_reg.second_operand;
    assign quot_final  = (op_reg.first_operand[31] ^ op_reg.second_operand[31])
                         ? (32'd0 - quo_reg) : quo_reg;
    assign rem_final   = op_reg.first_operand[31] ? (32'd0 - rem_reg) : rem_reg;

    always_comb
    begin
        alu_result = op_reg.first_operand;
        alu_halt   = 1'b0;
        case (op_reg.mode)
            OP_ADD, OP_JMP, OP_JAL:
                alu_result = op_reg.first_operand + op_reg.second_operand;
            OP_SUB:
                alu_result = op_reg.first_operand - op_reg.second_operand;
            OP_MUL:
                alu_result = mul_product;
            OP_QUOT, OP_REM:
            begin
                if (op_reg.second_operand == 32'd0)
                begin
                    alu_result = DIV_ZERO_VALUE;
                    alu_halt   = 1'b1;
                end
                else if (op_reg.mode == OP_QUOT)
                begin
                    alu_result = quot_final;
                end
                else
                begin
                    alu_result = rem_final;
                end
            end
            OP_SFTR:
                alu_result = $unsigned($signed(op_reg.first_operand)
                                       >>> op_reg.second_operand[4:0]);
            OP_SFTL:
                alu_result = op_reg.first_operand << op_reg.second_operand[4:0];
            OP_AND:
                alu_result = op_reg.first_operand & op_reg.second_operand;
            OP_OR:
                alu_result = op_reg.first_operand | op_reg.second_operand;
            OP_NOT:
                alu_result = ~op_reg.first_operand;
            OP_XOR:
                alu_result = op_reg.first_operand ^ op_reg.second_operand;
            OP_LOAD, OP_ADDI, OP_STORE, OP_PUSH, OP_POP:
                alu_result = op_reg.first_operand + op_reg.immediate_operand;
            OP_SUBI:
                alu_result = op_reg.first_operand - op_reg.immediate_operand;
            OP_SFTRI:
                alu_result = $unsigned($signed(op_reg.first_operand)
                                       >>> op_reg.immediate_operand[4:0]);
            OP_SFTLI:
                alu_result = op_reg.first_operand << op_reg.immediate_operand[4:0];
            OP_ANDI:
                alu_result = op_reg.first_operand & op_reg.immediate_operand;
            OP_ORI:
                alu_result = op_reg.first_operand | op_reg.immediate_operand;
            OP_XORI:
                alu_result = op_reg.first_operand ^ op_reg.immediate_operand;
            OP_JRL:
                alu_result = op_reg.program_counter + op_reg.second_operand;
            OP_BEQ:
                alu_result = equal_reg
                             ? (op_reg.program_counter + op_reg.second_operand) : NOT_TAKEN;
            OP_BGT:
                alu_result = greater_reg
                             ? (op_reg.program_counter + op_reg.second_operand) : NOT_TAKEN;
            OP_BUF:
                alu_result = op_reg.ext_underflow
                             ? (op_reg.program_counter + op_reg.second_operand) : NOT_TAKEN;
            OP_BOF:
                alu_result = op_reg.ext_overflow
                             ? (op_reg.program_counter + op_reg.second_operand) : NOT_TAKEN;
            default:
                alu_result = op_reg.first_operand;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        cnt_next        = cnt_reg;
        greater_next    = greater_reg;
        equal_next      = equal_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_result_next = out_result_reg;
        out_halt_next   = out_halt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next  = in_item;
                    rem_next = 32'd0;
                    quo_next = magnitude(in_item.first_operand);
                    dvs_next = magnitude(in_item.second_operand);
                    cnt_next = 5'd0;
                    state_next = in_div ? ST_DIV : ST_EXEC;
                end
            end
            ST_DIV:
            begin
                rem_next = div_borrow ? div_shifted[31:0] : div_diff[31:0];
                quo_next = {quo_reg[30:0], !div_borrow};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = alu_result;
                    out_halt_next   = alu_halt;
                    if (op_reg.mode == OP_CMP)
                    begin
                        greater_next = $signed(op_reg.first_operand)
                                       > $signed(op_reg.second_operand);
                        equal_next   = (op_reg.first_operand == op_reg.second_operand);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            greater_reg   <= 1'b0;
            equal_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            greater_reg   <= greater_next;
            equal_reg     <= equal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        cnt_reg        <= cnt_next;
        out_result_reg <= out_result_next;
        out_halt_reg   <= out_halt_next;
    end

    // A nonzero-divisor division goes through the divider loop.
    `ESALU_ASSERT_NEXT(a_div_enters_loop, clk, rst_n, in_accept && in_div, state_reg == ST_DIV, "division did not enter the divider loop")

    // The divider leaves after its last quotient bit.
    `ESALU_ASSERT_NEXT(a_div_leaves_loop, clk, rst_n, (state_reg == ST_DIV) && (cnt_reg == 5'd31), state_reg == ST_EXEC, "divider loop did not finish after 32 steps")

    // A new result is only ever loaded from the execute cycle.
    `ESALU_ASSERT_NOW(a_load_from_exec, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_EXEC, "output loaded outside the execute cycle")

    // Halt always comes with the saturated divide-by-zero value.
    `ESALU_ASSERT_NOW(a_halt_value, clk, rst_n, out_valid_reg && out_halt_reg, out_result_reg == DIV_ZERO_VALUE, "halt raised with an unexpected result")

endmodule
